// File: design/sset_pkg.sv
// ----------------------------------------------------------------------------
// sset_pkg: shared types and codes for the sorted set block
// Result status codes, operation codes and the control word that the
// sequencer broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package sset_pkg;

  localparam int KEY_W  = 32;
  localparam int DIST_W = 7;

  // operation codes (in_tuser)
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // result status codes (out_tuser)
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_PRESENT  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_QUERY    = 2'd3;

  localparam logic [DIST_W-1:0] DIST_MAX    = 7'd63;
  localparam logic [DIST_W-1:0] DIST_ABSENT = 7'h7F;

  typedef struct packed {
    logic                    cmp;   // compare every entry against key
    logic                    scan;  // move scan flags one cell toward the head
    logic                    ins;   // insert key at the lt/ge boundary
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// File: design/sset_cell.sv
// ----------------------------------------------------------------------------
// sset_cell: one slot of the sorted row
// Holds one entry and its valid flag, compares it with the broadcast key,
// shifts toward the tail on insert and passes scan flags toward the head.
// ----------------------------------------------------------------------------
module sset_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sset_pkg::cell_ctrl_t                ctrl,
  input  logic signed [sset_pkg::KEY_W-1:0]   prev_entry,
  input  logic                                prev_valid,
  input  logic                                prev_lt,
  input  logic                                next_sc_lt,
  input  logic                                next_sc_eq,
  output logic signed [sset_pkg::KEY_W-1:0]   entry,
  output logic                                valid,
  output logic                                lt,
  output logic                                sc_lt,
  output logic                                sc_eq
);

  logic signed [sset_pkg::KEY_W-1:0] entry_r, entry_nxt;
  logic valid_r, valid_nxt;
  logic lt_r, lt_nxt;
  logic sc_lt_r, sc_lt_nxt;
  logic sc_eq_r, sc_eq_nxt;
  logic cmp_lt, cmp_eq;

  assign cmp_lt = valid_r && (entry_r < ctrl.key);
  assign cmp_eq = valid_r && (entry_r == ctrl.key);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    lt_nxt    = lt_r;
    sc_lt_nxt = sc_lt_r;
    sc_eq_nxt = sc_eq_r;
    if (ctrl.cmp) begin
      lt_nxt    = cmp_lt;
      sc_lt_nxt = cmp_lt;
      sc_eq_nxt = cmp_eq;
    end else if (ctrl.scan) begin
      sc_lt_nxt = next_sc_lt;
      sc_eq_nxt = next_sc_eq;
    end
    if (ctrl.ins && !lt_r) begin
      // boundary cell takes the key, cells past it take their neighbor's entry
      entry_nxt = prev_lt ? ctrl.key : prev_entry;
      valid_nxt = valid_r | prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      sc_lt_r <= 1'b0;
      sc_eq_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      sc_lt_r <= sc_lt_nxt;
      sc_eq_r <= sc_eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;
  assign lt    = lt_r;
  assign sc_lt = sc_lt_r;
  assign sc_eq = sc_eq_r;

endmodule

// File: design/sorted_set_min_end_distance.sv
// ----------------------------------------------------------------------------
// sorted_set_min_end_distance: sorted set with insert and end-distance query
// Row of CAPACITY cells holding distinct signed values in ascending order.
// ----------------------------------------------------------------------------
// One item is handled at a time. After acceptance all cells compare the
// latched item in parallel, then the compare flags shift through the
// cell row to the head, where the position is counted as the number of
// stored entries below the item's value (at most CAPACITY), and a final
// step writes the result and, for an insert, shifts the row. That final
// step waits while an earlier result is still held in the output
// register. The input is ready only in the idle cycle that follows, so a
// new item is not taken before the last one is through; the result sits
// in an output register, so the next item is taken while it waits.
// Status on out_tuser: inserted, already present, full (dropped), query
// answered; out_tdata carries the distance, 7'h7F (127) if absent.
module sorted_set_min_end_distance #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] distance, [7] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > sset_pkg::DIST_W) ? CW : sset_pkg::DIST_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic op_r;
  logic signed [sset_pkg::KEY_W-1:0] key_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic found_r, found_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [sset_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;

  sset_pkg::cell_ctrl_t ctrl;
  logic signed [sset_pkg::KEY_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0] valid_w, lt_w, sc_lt_w, sc_eq_w;

  logic accept, out_free, full, ins_ok;
  logic [CW-1:0] left, right, dmin;
  logic [XW-1:0] dmin_x;
  logic [sset_pkg::DIST_W-1:0] dist_q;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_tvalid_r || out_tready;
  assign full     = valid_w[CAPACITY-1];
  assign ins_ok   = (op_r == sset_pkg::OP_INSERT) && !found_r && !full;

  assign ctrl.cmp  = (state_r == S_CMP);
  assign ctrl.scan = (state_r == S_SCAN) && sc_lt_w[0];
  assign ctrl.ins  = (state_r == S_DONE) && out_free && ins_ok;
  assign ctrl.key  = key_r;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [sset_pkg::KEY_W-1:0] p_entry;
      logic p_valid, p_lt, n_lt, n_eq;
      if (g == 0) begin : g_head
        assign p_entry = key_r;
        assign p_valid = 1'b1;
        assign p_lt    = 1'b1;
      end else begin : g_body
        assign p_entry = entry_w[g-1];
        assign p_valid = valid_w[g-1];
        assign p_lt    = lt_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign n_lt = 1'b0;
        assign n_eq = 1'b0;
      end else begin : g_mid
        assign n_lt = sc_lt_w[g+1];
        assign n_eq = sc_eq_w[g+1];
      end
      sset_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .prev_entry (p_entry),
        .prev_valid (p_valid),
        .prev_lt    (p_lt),
        .next_sc_lt (n_lt),
        .next_sc_eq (n_eq),
        .entry      (entry_w[g]),
        .valid      (valid_w[g]),
        .lt         (lt_w[g]),
        .sc_lt      (sc_lt_w[g]),
        .sc_eq      (sc_eq_w[g])
      );
    end
  endgenerate

  // distance from either end, position = cnt_r (0-based)
  assign left   = cnt_r + 1'b1;
  assign right  = count_r - cnt_r;
  assign dmin   = (left < right) ? left : right;
  assign dmin_x = XW'(dmin);
  assign dist_q = (dmin_x > XW'(sset_pkg::DIST_MAX)) ? sset_pkg::DIST_MAX
                                                     : dmin_x[sset_pkg::DIST_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    out_tvalid_nxt = out_tvalid_r;
    out_status_nxt = out_status_r;
    out_dist_nxt   = out_dist_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sc_lt_w[0]) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          found_nxt = sc_eq_w[0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
          if (op_r == sset_pkg::OP_QUERY) begin
            out_status_nxt = sset_pkg::ST_QUERY;
            out_dist_nxt   = found_r ? dist_q : sset_pkg::DIST_ABSENT;
          end else begin
            out_dist_nxt = '0;
            if (found_r) begin
              out_status_nxt = sset_pkg::ST_PRESENT;
            end else if (full) begin
              out_status_nxt = sset_pkg::ST_FULL;
            end else begin
              out_status_nxt = sset_pkg::ST_INSERTED;
              count_nxt      = count_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      cnt_r        <= cnt_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tuser;
      key_r <= $signed(in_tdata);
    end
    out_status_r <= out_status_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_dist_r};

  // valid cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_w >> 1) & ~valid_w) == '0)
    else $error("valid cells not contiguous from head");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CW'($countones(valid_w)))
    else $error("entry count disagrees with valid cells");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("insert did not grow the set by one");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> cnt_r <= count_r)
    else $error("scan position ran past the stored entries");

endmodule
